>>> hw/rtl/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared constants, codes, state type and command/status structs of the
// cross-covariance loss unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ccl_pkg;

  // Batch and store geometry
  localparam int MAX_SAMPLES = 64;
  localparam int MAX_DIM_X   = 32;
  localparam int MAX_DIM_Y   = 32;
  localparam int SAMPLE_W    = 6;
  localparam int FEAT_W      = 5;
  localparam int ADDR_W      = SAMPLE_W + FEAT_W;
  localparam int STORE_DEPTH = MAX_SAMPLES * MAX_DIM_X;

  // Field and register widths
  localparam int VALUE_W    = 16;
  localparam int NUM_W      = 7;
  localparam int DIM_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int OP_W       = 2;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Datapath widths
  localparam int SUM_W    = 23;  // per-feature batch sum
  localparam int SCALED_W = 24;  // N * value
  localparam int DIFF_W   = 24;  // centred value times N
  localparam int PROD_W   = 48;
  localparam int ACC_W    = 52;
  localparam int NSQ_W    = 14;
  localparam int N3_W     = 19;
  localparam int DVD_W    = 53;
  localparam int QUOT_W   = 33;
  localparam int SQ_W     = 66;
  localparam int TOTAL_W  = 76;
  localparam int RSHIFT   = 17;
  localparam int ROUND_W  = TOTAL_W - RSHIFT;
  localparam int LOSS_W   = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_X  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_Y  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y       = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUMX_RUN,
    ST_SUMX_DRAIN,
    ST_SUMY_RUN,
    ST_SUMY_DRAIN,
    ST_COV_RUN,
    ST_COV_DRAIN,
    ST_COV_ABS,
    ST_DIV_WAIT,
    ST_SQR_ACC,
    ST_ROUND,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic                issue;
    logic                cov;
    logic                sel_y;
    logic                clear_acc;
    logic                store_sum;
    logic                div_start;
    logic                sqr_step;
    logic                sqr_acc;
    logic                clear_total;
    logic                round_step;
    logic                finish;
    logic [SAMPLE_W-1:0] sample;
    logic [FEAT_W-1:0]   fi;
    logic [FEAT_W-1:0]   fj;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic               we_x;
    logic               we_y;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
  } load_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/ccl_ram.sv
// ----------------------------------------------------------------------------
// ccl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ccl_div.sv
// ----------------------------------------------------------------------------
// ccl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ccl_pkg::DVD_W-1:0] dividend,
  input  wire logic [ccl_pkg::N3_W-1:0]  divisor,
  output logic      [ccl_pkg::DVD_W-1:0] quotient,
  output logic                           done
);
  import ccl_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N3_W-1:0]  rem;
  logic [N3_W-1:0]  dsr;
  logic [DVD_W-1:0] dvd;
  logic [N3_W:0]    trial;
  logic             fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // Control: count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Datapath: shift quotient bits into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      rem <= fits ? N3_W'(trial - {1'b0, dsr}) : trial[N3_W-1:0];
      dvd <= {dvd[DVD_W-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

>>> hw/rtl/ccl_datapath.sv
// ----------------------------------------------------------------------------
// ccl_datapath
// Sample stores, batch sums, centring and product pipeline, divider,
// squaring and loss accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ccl_pkg::dp_cmd_t           cmd,
  output ccl_pkg::dp_stat_t               stat,
  input  wire ccl_pkg::load_req_t         load,
  input  wire logic [ccl_pkg::NUM_W-1:0]  n_use,
  output logic      [ccl_pkg::LOSS_W-1:0] loss,
  output logic                            saturated
);
  import ccl_pkg::*;

  logic [VALUE_W-1:0]        x_rdata;
  logic [VALUE_W-1:0]        y_rdata;
  logic                      v1, v2, v3, v4;
  logic                      cov1, sely1;
  logic signed [SCALED_W-1:0] nxv, nyv;
  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]           mag;
  logic [SUM_W-1:0]           x_sum [MAX_DIM_X];
  logic [SUM_W-1:0]           y_sum [MAX_DIM_Y];
  logic [VALUE_W-1:0]         sum_val;
  logic [NSQ_W-1:0]           n_sq;
  logic [NSQ_W+NUM_W-1:0]     cube_full;
  logic [N3_W-1:0]            n_cube;
  logic [DVD_W-1:0]           dividend;
  logic [DVD_W-1:0]           quot;
  logic [QUOT_W-1:0]          a;
  logic [SQ_W-1:0]            sq;
  logic [TOTAL_W-1:0]         total;
  logic [TOTAL_W-1:0]         total_rnd;
  logic [ROUND_W-1:0]         rounded;

  // Sample stores
  ccl_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_x_store (
    .clk   (clk),
    .we    (load.we_x),
    .waddr (load.addr),
    .wdata (load.value),
    .raddr ({cmd.sample, cmd.fi}),
    .rdata (x_rdata)
  );

  ccl_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_y_store (
    .clk   (clk),
    .we    (load.we_y),
    .waddr (load.addr),
    .wdata (load.value),
    .raddr ({cmd.sample, cmd.fj}),
    .rdata (y_rdata)
  );

  // Batch size powers, registered between multiplies
  assign cube_full = {{NUM_W{1'b0}}, n_sq} * {{NSQ_W{1'b0}}, n_use};
  always_ff @(posedge clk) begin
    n_sq   <= NSQ_W'({{NUM_W{1'b0}}, n_use} * {{NUM_W{1'b0}}, n_use});
    n_cube <= cube_full[N3_W-1:0];
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1 & cov1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign stat.pipe_busy = v1 | v2 | v3 | v4;

  // Stage 1: scale by N; stage 2: centre; stage 3: product
  always_ff @(posedge clk) begin
    cov1  <= cmd.cov;
    sely1 <= cmd.sel_y;
    nxv   <= $signed({1'b0, n_use}) * $signed(x_rdata);
    nyv   <= $signed({1'b0, n_use}) * $signed(y_rdata);
    dx    <= nxv - $signed({x_sum[cmd.fi][SUM_W-1], x_sum[cmd.fi]});
    dy    <= nyv - $signed({y_sum[cmd.fj][SUM_W-1], y_sum[cmd.fj]});
    prod  <= dx * dy;
  end

  assign sum_val = sely1 ? y_rdata : x_rdata;

  // Shared accumulator: raw sums, then cross products
  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc <= '0;
    end else if (v1 && !cov1) begin
      acc <= acc + {{(ACC_W-VALUE_W){sum_val[VALUE_W-1]}}, sum_val};
    end else if (v4) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Hold the feature sums
  always_ff @(posedge clk) begin
    if (cmd.store_sum) begin
      if (cmd.sel_y) begin
        y_sum[cmd.fj] <= acc[SUM_W-1:0];
      end else begin
        x_sum[cmd.fi] <= acc[SUM_W-1:0];
      end
    end
  end

  // Magnitude of the cross sum, then divide by N cubed with rounding
  always_ff @(posedge clk) begin
    mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  end

  assign dividend = {1'b0, mag} + {{(DVD_W-N3_W+1){1'b0}}, n_cube[N3_W-1:1]};

  ccl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (n_cube),
    .quotient (quot),
    .done     (stat.div_done)
  );

  assign a = quot[QUOT_W-1:0];

  // Square each entry and sum exactly
  always_ff @(posedge clk) begin
    if (cmd.sqr_step) begin
      sq <= {{(SQ_W-QUOT_W){1'b0}}, a} * {{(SQ_W-QUOT_W){1'b0}}, a};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_total) begin
      total <= '0;
    end else if (cmd.sqr_acc) begin
      total <= total + {{(TOTAL_W-SQ_W){1'b0}}, sq};
    end
  end

  // Round half up to 15 fraction bits
  assign total_rnd = total + (TOTAL_W'(1) << (RSHIFT - 1));
  always_ff @(posedge clk) begin
    if (cmd.round_step) begin
      rounded <= total_rnd[TOTAL_W-1:RSHIFT];
    end
  end

  // Saturate to the loss width
  assign saturated = |rounded[ROUND_W-1:LOSS_W];
  assign loss      = saturated ? {LOSS_W{1'b1}} : rounded[LOSS_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/ccl_ctrl.sv
// ----------------------------------------------------------------------------
// ccl_ctrl
// Sequencer: walks sums, cross products, division and squaring per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ccl_pkg::NUM_W-1:0]  n_use,
  input  wire logic [ccl_pkg::DIM_W-1:0]  nx_use,
  input  wire logic [ccl_pkg::DIM_W-1:0]  ny_use,
  input  wire logic                       out_free,
  input  wire ccl_pkg::dp_stat_t          stat,
  output ccl_pkg::dp_cmd_t                cmd,
  output logic                            ready
);
  import ccl_pkg::*;

  ctrl_state_t         state, state_next;
  logic [SAMPLE_W-1:0] s_cnt, s_cnt_next;
  logic [FEAT_W-1:0]   fi, fi_next;
  logic [FEAT_W-1:0]   fj, fj_next;
  logic [NUM_W-1:0]    n_m1;
  logic [DIM_W-1:0]    nx_m1, ny_m1;
  logic [SAMPLE_W-1:0] n_last;
  logic [FEAT_W-1:0]   nx_last, ny_last;

  assign n_m1    = n_use - NUM_W'(1);
  assign nx_m1   = nx_use - DIM_W'(1);
  assign ny_m1   = ny_use - DIM_W'(1);
  assign n_last  = n_m1[SAMPLE_W-1:0];
  assign nx_last = nx_m1[FEAT_W-1:0];
  assign ny_last = ny_m1[FEAT_W-1:0];

  // State and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      s_cnt <= '0;
      fi    <= '0;
      fj    <= '0;
    end else begin
      state <= state_next;
      s_cnt <= s_cnt_next;
      fi    <= fi_next;
      fj    <= fj_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    s_cnt_next = s_cnt;
    fi_next    = fi;
    fj_next    = fj;
    cmd        = '0;
    cmd.sample = s_cnt;
    cmd.fi     = fi;
    cmd.fj     = fj;
    ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          cmd.clear_acc   = 1'b1;
          cmd.clear_total = 1'b1;
          s_cnt_next      = '0;
          fi_next         = '0;
          fj_next         = '0;
          state_next      = ST_SUMX_RUN;
        end
      end
      ST_SUMX_RUN: begin
        cmd.issue = 1'b1;
        if (s_cnt == n_last) begin
          s_cnt_next = '0;
          state_next = ST_SUMX_DRAIN;
        end else begin
          s_cnt_next = s_cnt + SAMPLE_W'(1);
        end
      end
      ST_SUMX_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.store_sum = 1'b1;
          cmd.clear_acc = 1'b1;
          if (fi == nx_last) begin
            fi_next    = '0;
            state_next = ST_SUMY_RUN;
          end else begin
            fi_next    = fi + FEAT_W'(1);
            state_next = ST_SUMX_RUN;
          end
        end
      end
      ST_SUMY_RUN: begin
        cmd.issue = 1'b1;
        cmd.sel_y = 1'b1;
        if (s_cnt == n_last) begin
          s_cnt_next = '0;
          state_next = ST_SUMY_DRAIN;
        end else begin
          s_cnt_next = s_cnt + SAMPLE_W'(1);
        end
      end
      ST_SUMY_DRAIN: begin
        cmd.sel_y = 1'b1;
        if (!stat.pipe_busy) begin
          cmd.store_sum = 1'b1;
          cmd.clear_acc = 1'b1;
          if (fj == ny_last) begin
            fj_next    = '0;
            state_next = ST_COV_RUN;
          end else begin
            fj_next    = fj + FEAT_W'(1);
            state_next = ST_SUMY_RUN;
          end
        end
      end
      ST_COV_RUN: begin
        cmd.issue = 1'b1;
        cmd.cov   = 1'b1;
        if (s_cnt == n_last) begin
          s_cnt_next = '0;
          state_next = ST_COV_DRAIN;
        end else begin
          s_cnt_next = s_cnt + SAMPLE_W'(1);
        end
      end
      ST_COV_DRAIN: begin
        cmd.cov = 1'b1;
        if (!stat.pipe_busy) begin
          state_next = ST_COV_ABS;
        end
      end
      ST_COV_ABS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.sqr_step = 1'b1;
          state_next   = ST_SQR_ACC;
        end
      end
      ST_SQR_ACC: begin
        cmd.sqr_acc   = 1'b1;
        cmd.clear_acc = 1'b1;
        if (fj == ny_last) begin
          fj_next = '0;
          if (fi == nx_last) begin
            state_next = ST_ROUND;
          end else begin
            fi_next    = fi + FEAT_W'(1);
            state_next = ST_COV_RUN;
          end
        end else begin
          fj_next    = fj + FEAT_W'(1);
          state_next = ST_COV_RUN;
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/cross_covariance_loss_unit.sv
// ----------------------------------------------------------------------------
// cross_covariance_loss_unit
// Batch cross-covariance penalty loss over Q7.8 samples held in on-chip RAM.
// ----------------------------------------------------------------------------
// Loads take one request per cycle while the unit is idle and give no result.
// A compute request walks the batch sums, then for each matrix entry the
// one-sample-per-cycle product pipeline and the 53-step divider, before its
// result is raised; one request is in flight.
// The result waits in an output register; loads are taken meanwhile.
// Reset sets the registers to 1 and clears control; the stores are not cleared.
`default_nettype none

module cross_covariance_loss_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [5:0] sample, [10:6] feature, [26:11] value, rest zero
  input  wire logic [ccl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [1:0] op
  input  wire logic [ccl_pkg::OP_W-1:0]            s_axis_tuser,
  // Result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [47:0] loss, [48] saturated, rest zero
  output logic      [ccl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [ccl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ccl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ccl_pkg::*;

  logic [NUM_W-1:0]  num_samples;
  logic [DIM_W-1:0]  dim_x;
  logic [DIM_W-1:0]  dim_y;
  logic [NUM_W-1:0]  n_use;
  logic [DIM_W-1:0]  nx_use, ny_use;
  logic              in_accept;
  logic              start;
  logic              ready;
  logic              out_free;
  load_req_t         load;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [LOSS_W-1:0] loss;
  logic              saturated;
  logic [LOSS_W-1:0] out_loss;
  logic              out_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples <= NUM_W'(1);
      dim_x       <= DIM_W'(1);
      dim_y       <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_SAMPLES: num_samples <= cfg_data;
        REG_DIM_X:       dim_x       <= cfg_data[DIM_W-1:0];
        REG_DIM_Y:       dim_y       <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to their usable ranges
  always_comb begin
    if (num_samples == '0) begin
      n_use = NUM_W'(1);
    end else if (num_samples > NUM_W'(MAX_SAMPLES)) begin
      n_use = NUM_W'(MAX_SAMPLES);
    end else begin
      n_use = num_samples;
    end
    if (dim_x == '0) begin
      nx_use = DIM_W'(1);
    end else if (dim_x > DIM_W'(MAX_DIM_X)) begin
      nx_use = DIM_W'(MAX_DIM_X);
    end else begin
      nx_use = dim_x;
    end
    if (dim_y == '0) begin
      ny_use = DIM_W'(1);
    end else if (dim_y > DIM_W'(MAX_DIM_Y)) begin
      ny_use = DIM_W'(MAX_DIM_Y);
    end else begin
      ny_use = dim_y;
    end
  end

  // Decode input requests
  assign s_axis_tready = ready;
  assign in_accept     = s_axis_tvalid & ready;
  assign start         = in_accept & (s_axis_tuser == OP_COMPUTE);
  assign load.we_x     = in_accept & (s_axis_tuser == OP_LOAD_X);
  assign load.we_y     = in_accept & (s_axis_tuser == OP_LOAD_Y);
  assign load.addr     = {s_axis_tdata[SAMPLE_W-1:0], s_axis_tdata[ADDR_W-1:SAMPLE_W]};
  assign load.value    = s_axis_tdata[ADDR_W+VALUE_W-1:ADDR_W];

  assign out_free = ~m_axis_tvalid | m_axis_tready;

  ccl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .n_use    (n_use),
    .nx_use   (nx_use),
    .ny_use   (ny_use),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .ready    (ready)
  );

  ccl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .load      (load),
    .n_use     (n_use),
    .loss      (loss),
    .saturated (saturated)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_loss <= loss;
      out_sat  <= saturated;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-LOSS_W-1){1'b0}}, out_sat, out_loss};

endmodule

`default_nettype wire
